@@ rtl/iscb_pkg.sv @@
// Shared types and constants for the integer scaled clipped blit unit.
// No dependencies; the top level and iscb_csr refer to it by scoped names.
package iscb_pkg;

   // Fixed field widths of the register file and the channels.
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int SRC_DIM_W   = 11;
   localparam int SCALE_W     = 4;
   localparam int OFFSET_W    = 13;
   localparam int DISP_DIM_W  = 13;
   localparam int PITCH_W     = 14;
   localparam int COLOUR_W    = 32;
   localparam int INDEX_W     = 25;
   localparam int REG_INDEX_W = 3;

   // Register indexes (byte address = 4 * index).
   localparam logic [REG_INDEX_W-1:0] REG_SOURCE_WIDTH   = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_SOURCE_HEIGHT  = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_SCALE_FACTOR   = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_X_OFFSET       = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_Y_OFFSET       = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_DISPLAY_WIDTH  = 3'd5;
   localparam logic [REG_INDEX_W-1:0] REG_DISPLAY_HEIGHT = 3'd6;
   localparam logic [REG_INDEX_W-1:0] REG_LINE_PITCH     = 3'd7;

   // Reset values.
   localparam logic [SRC_DIM_W-1:0]  RST_SOURCE_WIDTH   = 11'd256;
   localparam logic [SRC_DIM_W-1:0]  RST_SOURCE_HEIGHT  = 11'd240;
   localparam logic [SCALE_W-1:0]    RST_SCALE_FACTOR   = 4'd1;
   localparam logic [OFFSET_W-1:0]   RST_OFFSET         = 13'd0;
   localparam logic [DISP_DIM_W-1:0] RST_DISPLAY_WIDTH  = 13'd640;
   localparam logic [DISP_DIM_W-1:0] RST_DISPLAY_HEIGHT = 13'd480;
   localparam logic [PITCH_W-1:0]    RST_LINE_PITCH     = 14'd640;

   typedef struct packed {
      logic [SRC_DIM_W-1:0]         source_width;
      logic [SRC_DIM_W-1:0]         source_height;
      logic [SCALE_W-1:0]           scale_factor;
      logic signed [OFFSET_W-1:0]   x_offset;
      logic signed [OFFSET_W-1:0]   y_offset;
      logic [DISP_DIM_W-1:0]        display_width;
      logic [DISP_DIM_W-1:0]        display_height;
      logic [PITCH_W-1:0]           line_pitch;
   } cfg_regs_type;

endpackage

@@ rtl/integer_scaled_clipped_blit_unit.sv @@
// Top level of the integer scaled clipped blit unit: sequencer, clip masks,
// source counters and output register. Depends on iscb_pkg, iscb_csr, iscb_muladd.
//
// Each accepted source pixel is replicated into a scale x scale block placed at
// (x_offset + column*scale, y_offset + row*scale); every block pixel inside the
// display yields one write transfer carrying column + row*pitch and the colour,
// emitted row by row, with last_write set on the final one. One multiply-add
// unit does all address arithmetic under a small sequencer, so the unit takes
// one item at a time: setup (accept, horizontal base, vertical base, clip
// masks), then for each block row up to the last visible one, a row step
// (row address, or skip of a clipped row), and for each visible row one
// column step per column up to its last visible column. A fully clipped
// block or a scale of zero ends after setup. A write waits while the output
// register holds an untaken transfer; the next item is accepted while the
// last write still waits.
module integer_scaled_clipped_blit_unit #(
   parameter int MAX_SCALE       = 8,
   parameter int MAX_SOURCE_DIM  = 1024,
   parameter int MAX_DISPLAY_DIM = 4096,
   parameter int MAX_PITCH       = 8192
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [iscb_pkg::COLOUR_W-1:0]     req_pixel_colour,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [iscb_pkg::INDEX_W-1:0]      rsp_pixel_index,
   output logic [iscb_pkg::COLOUR_W-1:0]     rsp_write_colour,
   output logic                              rsp_last_write,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [iscb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [iscb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [iscb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // Source counter width, block index width, coordinate and unit widths.
   localparam int SRC_W  = $clog2(MAX_SOURCE_DIM);
   localparam int IW     = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int SPAN_W = $clog2(MAX_SOURCE_DIM * MAX_SCALE);
   localparam int PW     = ((SPAN_W > iscb_pkg::OFFSET_W) ? SPAN_W : iscb_pkg::OFFSET_W) + 2;
   localparam int DISP_W = $clog2(MAX_DISPLAY_DIM);
   localparam int AW     = (SRC_W > DISP_W) ? SRC_W : DISP_W;
   localparam int RW     = (AW + 16 > 26) ? AW + 16 : 26;

   typedef enum logic [2:0] {
      S_IDLE,
      S_XBASE,
      S_YBASE,
      S_MASK,
      S_ROW,
      S_WRITE
   } state_type;

   iscb_pkg::cfg_regs_type cfg;

   // Effective (clamped) configuration.
   logic [SRC_W:0]                   sw_eff;
   logic [SRC_W:0]                   sh_eff;
   logic [iscb_pkg::SCALE_W-1:0]     sc_eff;
   logic [13:0]                      dw_eff;
   logic [13:0]                      dh_eff;
   logic [iscb_pkg::PITCH_W-1:0]     pitch_eff;

   // Sequencer and datapath registers.
   state_type                        state_ff, state_in;
   logic [iscb_pkg::COLOUR_W-1:0]    colour_ff, colour_in;
   logic [SRC_W-1:0]                 col_ff, col_in;
   logic [SRC_W-1:0]                 row_ff, row_in;
   logic [SRC_W-1:0]                 col_work_ff, col_work_in;
   logic [SRC_W-1:0]                 row_work_ff, row_work_in;
   logic signed [PW-1:0]             x0_ff, x0_in;
   logic signed [PW-1:0]             y0_ff, y0_in;
   logic [MAX_SCALE-1:0]             xmask_ff, xmask_in;
   logic [MAX_SCALE-1:0]             ymask_ff, ymask_in;
   logic [IW-1:0]                    last_dx_ff, last_dx_in;
   logic [IW-1:0]                    last_dy_ff, last_dy_in;
   logic [IW-1:0]                    dx_ff, dx_in;
   logic [IW-1:0]                    dy_ff, dy_in;
   logic signed [RW-1:0]             row_base_ff, row_base_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [iscb_pkg::INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [iscb_pkg::COLOUR_W-1:0]    rsp_colour_ff, rsp_colour_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Shared unit operands.
   logic [AW-1:0]                    mu_a;
   logic [iscb_pkg::PITCH_W-1:0]     mu_b;
   logic signed [RW-1:0]             mu_c;
   logic signed [RW-1:0]             mu_r;

   logic signed [PW-1:0]             px;
   logic signed [PW-1:0]             py;
   logic [MAX_SCALE-1:0]             xmask_new;
   logic [MAX_SCALE-1:0]             ymask_new;
   logic                             accept;
   logic                             out_free;
   logic                             load;
   logic                             load_last;
   logic                             col_wrap;
   logic                             row_wrap;

   // Mark block offsets d < scale whose coordinate base + d lies in [0, lim).
   function automatic logic [MAX_SCALE-1:0] axis_mask(
      input logic signed [PW-1:0]        base,
      input logic [iscb_pkg::SCALE_W-1:0] sc,
      input logic [13:0]                 lim
   );
      logic signed [PW:0]   pos;
      logic [MAX_SCALE-1:0] m;
      m = '0;
      for (int d = 0; d < MAX_SCALE; d++) begin
         pos  = signed'({base[PW-1], base}) + signed'((PW+1)'(d));
         m[d] = (5'(d) < {1'b0, sc}) && !pos[PW] && (pos < signed'((PW+1)'(lim)));
      end
      return m;
   endfunction

   // Highest set position of a mask.
   function automatic logic [IW-1:0] top_bit(input logic [MAX_SCALE-1:0] m);
      logic [IW-1:0] idx;
      idx = '0;
      for (int d = 0; d < MAX_SCALE; d++) begin
         if (m[d]) idx = IW'(d);
      end
      return idx;
   endfunction

   iscb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   iscb_muladd #(
      .AW (AW),
      .BW (iscb_pkg::PITCH_W),
      .RW (RW)
   ) u_muladd (
      .a (mu_a),
      .b (mu_b),
      .c (mu_c),
      .r (mu_r)
   );

   assign csr_pready = 1'b1;

   // Clamp configuration to the supported ranges; zero source sizes act as one.
   always_comb begin
      if (cfg.source_width == '0) begin
         sw_eff = (SRC_W+1)'(1);
      end else if (13'(cfg.source_width) > 13'(MAX_SOURCE_DIM)) begin
         sw_eff = (SRC_W+1)'(MAX_SOURCE_DIM);
      end else begin
         sw_eff = (SRC_W+1)'(cfg.source_width);
      end
      if (cfg.source_height == '0) begin
         sh_eff = (SRC_W+1)'(1);
      end else if (13'(cfg.source_height) > 13'(MAX_SOURCE_DIM)) begin
         sh_eff = (SRC_W+1)'(MAX_SOURCE_DIM);
      end else begin
         sh_eff = (SRC_W+1)'(cfg.source_height);
      end
      sc_eff = (cfg.scale_factor > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : cfg.scale_factor;
      dw_eff = (14'(cfg.display_width) > 14'(MAX_DISPLAY_DIM)) ?
               14'(MAX_DISPLAY_DIM) : 14'(cfg.display_width);
      dh_eff = (14'(cfg.display_height) > 14'(MAX_DISPLAY_DIM)) ?
               14'(MAX_DISPLAY_DIM) : 14'(cfg.display_height);
      pitch_eff = (15'(cfg.line_pitch) > 15'(MAX_PITCH)) ?
                  iscb_pkg::PITCH_W'(MAX_PITCH) : cfg.line_pitch;
   end

   // Current target coordinates inside the block.
   assign px = x0_ff + signed'(PW'(dx_ff));
   assign py = y0_ff + signed'(PW'(dy_ff));

   assign xmask_new = axis_mask(x0_ff, sc_eff, dw_eff);
   assign ymask_new = axis_mask(y0_ff, sc_eff, dh_eff);

   // Operand selection for the shared multiply-add unit.
   always_comb begin
      unique case (state_ff)
         S_XBASE: begin
            mu_a = AW'(col_work_ff);
            mu_b = iscb_pkg::PITCH_W'(sc_eff);
            mu_c = RW'(cfg.x_offset);
         end
         S_YBASE: begin
            mu_a = AW'(row_work_ff);
            mu_b = iscb_pkg::PITCH_W'(sc_eff);
            mu_c = RW'(cfg.y_offset);
         end
         S_ROW: begin
            mu_a = py[AW-1:0];
            mu_b = pitch_eff;
            mu_c = '0;
         end
         default: begin
            mu_a = px[AW-1:0];
            mu_b = iscb_pkg::PITCH_W'(1);
            mu_c = row_base_ff;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = (state_ff == S_WRITE) && xmask_ff[dx_ff] && out_free;
   assign load_last = (dx_ff == last_dx_ff) && (dy_ff == last_dy_ff);
   assign col_wrap  = ({1'b0, col_ff} + (SRC_W+1)'(1)) >= sw_eff;
   assign row_wrap  = ({1'b0, row_ff} + (SRC_W+1)'(1)) >= sh_eff;

   always_comb begin
      state_in      = state_ff;
      colour_in     = colour_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      col_work_in   = col_work_ff;
      row_work_in   = row_work_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      xmask_in      = xmask_ff;
      ymask_in      = ymask_ff;
      last_dx_in    = last_dx_ff;
      last_dy_in    = last_dy_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      row_base_in   = row_base_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Snapshot the counters for this pixel, then advance them.
               colour_in   = req_pixel_colour;
               col_work_in = col_ff;
               row_work_in = row_ff;
               if (col_wrap) begin
                  col_in = '0;
                  row_in = row_wrap ? '0 : row_ff + SRC_W'(1);
               end else begin
                  col_in = col_ff + SRC_W'(1);
               end
               state_in = S_XBASE;
            end
         end
         S_XBASE: begin
            x0_in    = mu_r[PW-1:0];
            state_in = S_YBASE;
         end
         S_YBASE: begin
            y0_in    = mu_r[PW-1:0];
            state_in = S_MASK;
         end
         S_MASK: begin
            xmask_in   = xmask_new;
            ymask_in   = ymask_new;
            last_dx_in = top_bit(xmask_new);
            last_dy_in = top_bit(ymask_new);
            dy_in      = '0;
            // Drop the pixel when its whole block is clipped or scale is zero.
            state_in   = ((xmask_new == '0) || (ymask_new == '0)) ? S_IDLE : S_ROW;
         end
         S_ROW: begin
            if (ymask_ff[dy_ff]) begin
               row_base_in = mu_r;
               dx_in       = '0;
               state_in    = S_WRITE;
            end else begin
               dy_in = dy_ff + IW'(1);
            end
         end
         S_WRITE: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = mu_r[iscb_pkg::INDEX_W-1:0];
               rsp_colour_in = colour_ff;
               rsp_last_in   = load_last;
            end
            // Hold on a visible column until the output register frees up.
            if (!xmask_ff[dx_ff] || out_free) begin
               if (dx_ff == last_dx_ff) begin
                  if (dy_ff == last_dy_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     dy_in    = dy_ff + IW'(1);
                     state_in = S_ROW;
                  end
               end else begin
                  dx_in = dx_ff + IW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      colour_ff     <= colour_in;
      col_work_ff   <= col_work_in;
      row_work_ff   <= row_work_in;
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      xmask_ff      <= xmask_in;
      ymask_ff      <= ymask_in;
      last_dx_ff    <= last_dx_in;
      last_dy_ff    <= last_dy_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      row_base_ff   <= row_base_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_index  = rsp_index_ff;
   assign rsp_write_colour = rsp_colour_ff;
   assign rsp_last_write   = rsp_last_ff;

   // A write is only issued for a block position inside the display.
   a_write_visible: assert property (@(posedge clock) disable iff (reset)
      load |-> (xmask_ff[dx_ff] && ymask_ff[dy_ff]))
      else $error("write issued for a clipped block position");

   // The final write of a pixel ends its work.
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (load && load_last) |=> (state_ff == S_IDLE))
      else $error("sequencer kept running after the last write");

   // The column walk never passes the last visible position.
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> ((dx_ff <= last_dx_ff) && (dy_ff <= last_dy_ff)))
      else $error("block walk past last visible position");

endmodule

@@ rtl/iscb_csr.sv @@
// Configuration register file with an APB-style access port.
// Depends on iscb_pkg for register indexes, widths and reset values.
module iscb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [iscb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [iscb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [iscb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output iscb_pkg::cfg_regs_type            cfg
);

   iscb_pkg::cfg_regs_type                  regs_ff;
   iscb_pkg::cfg_regs_type                  regs_in;
   logic [iscb_pkg::REG_INDEX_W-1:0]        reg_index;
   logic                                    write_en;

   assign reg_index = csr_paddr[iscb_pkg::CSR_ADDR_W-1:2];
   assign write_en  = csr_psel & csr_penable & csr_pwrite;
   assign cfg       = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         unique case (reg_index)
            iscb_pkg::REG_SOURCE_WIDTH:   regs_in.source_width   = csr_pwdata[10:0];
            iscb_pkg::REG_SOURCE_HEIGHT:  regs_in.source_height  = csr_pwdata[10:0];
            iscb_pkg::REG_SCALE_FACTOR:   regs_in.scale_factor   = csr_pwdata[3:0];
            iscb_pkg::REG_X_OFFSET:       regs_in.x_offset       = csr_pwdata[12:0];
            iscb_pkg::REG_Y_OFFSET:       regs_in.y_offset       = csr_pwdata[12:0];
            iscb_pkg::REG_DISPLAY_WIDTH:  regs_in.display_width  = csr_pwdata[12:0];
            iscb_pkg::REG_DISPLAY_HEIGHT: regs_in.display_height = csr_pwdata[12:0];
            iscb_pkg::REG_LINE_PITCH:     regs_in.line_pitch     = csr_pwdata[13:0];
         endcase
      end
   end

   // Read back the stored value, zero extended.
   always_comb begin
      unique case (reg_index)
         iscb_pkg::REG_SOURCE_WIDTH:   csr_prdata = {21'd0, regs_ff.source_width};
         iscb_pkg::REG_SOURCE_HEIGHT:  csr_prdata = {21'd0, regs_ff.source_height};
         iscb_pkg::REG_SCALE_FACTOR:   csr_prdata = {28'd0, regs_ff.scale_factor};
         iscb_pkg::REG_X_OFFSET:       csr_prdata = {19'd0, regs_ff.x_offset};
         iscb_pkg::REG_Y_OFFSET:       csr_prdata = {19'd0, regs_ff.y_offset};
         iscb_pkg::REG_DISPLAY_WIDTH:  csr_prdata = {19'd0, regs_ff.display_width};
         iscb_pkg::REG_DISPLAY_HEIGHT: csr_prdata = {19'd0, regs_ff.display_height};
         iscb_pkg::REG_LINE_PITCH:     csr_prdata = {18'd0, regs_ff.line_pitch};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.source_width   <= iscb_pkg::RST_SOURCE_WIDTH;
         regs_ff.source_height  <= iscb_pkg::RST_SOURCE_HEIGHT;
         regs_ff.scale_factor   <= iscb_pkg::RST_SCALE_FACTOR;
         regs_ff.x_offset       <= iscb_pkg::RST_OFFSET;
         regs_ff.y_offset       <= iscb_pkg::RST_OFFSET;
         regs_ff.display_width  <= iscb_pkg::RST_DISPLAY_WIDTH;
         regs_ff.display_height <= iscb_pkg::RST_DISPLAY_HEIGHT;
         regs_ff.line_pitch     <= iscb_pkg::RST_LINE_PITCH;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

@@ rtl/iscb_muladd.sv @@
// Shared multiply-add unit: r = a * b + c, unsigned a and b, signed c.
// No package dependency; the caller registers the result.
module iscb_muladd #(
   parameter int AW = 13,
   parameter int BW = 14,
   parameter int RW = 29
) (
   input  logic [AW-1:0]        a,
   input  logic [BW-1:0]        b,
   input  logic signed [RW-1:0] c,
   output logic signed [RW-1:0] r
);

   logic [AW+BW-1:0] prod;

   assign prod = a * b;
   assign r    = signed'(RW'(prod)) + c;

endmodule
